/* rtl/cfsb_pkg.sv */
// Shared constants and types for the coarse/fine stencil box block.
// No dependencies; imported by cfsb_fdiv and coarse_fine_stencil_box_top.
package cfsb_pkg;

    // Default coordinate width and quotient bits retired per divider stage
    localparam int COORD_BITS_DEF = 24;
    localparam int DIV_DIGITS     = 4;

    // Configuration field widths
    localparam int AXES_W     = 2;
    localparam int REFINE_W   = 5;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_AXES = 3'd0,
        CFG_REFINE_X    = 3'd1,
        CFG_REFINE_Y    = 3'd2,
        CFG_REFINE_Z    = 3'd3,
        CFG_STEP_X      = 3'd4,
        CFG_STEP_Y      = 3'd5,
        CFG_STEP_Z      = 3'd6
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [AXES_W-1:0]   ACTIVE_AXES_RST = 2'd3;
    localparam logic [REFINE_W-1:0] REFINE_RST      = 5'd2;
    localparam logic [STEP_W-1:0]   STEP_RST        = 2'b00;

    // Stencil step encodings (two's complement)
    localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
    localparam logic [STEP_W-1:0] STEP_POS  = 2'b01;
    localparam logic [STEP_W-1:0] STEP_NEG2 = 2'b10;
    localparam logic [STEP_W-1:0] STEP_NEG  = 2'b11;

endpackage

/* rtl/coarse_fine_stencil_box_top.sv */
// Coarse/fine stencil coupling box: maps a fine box to coarse, grows and clips it,
// and intersects the stencil-shifted extents. Depends on cfsb_pkg and cfsb_fdiv.
// The floor dividers set the pipeline depth; they retire four quotient bits per pipeline stage.
// Throughput: one item per cycle; busy stays low and results cannot be stalled.
// Reset (synchronous, active low) empties the pipeline and restores the register defaults.
module coarse_fine_stencil_box_top
    import cfsb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         start,
    output logic                         busy,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  logic signed [COORD_BITS-1:0] i_fine_lo_x,
    input  logic signed [COORD_BITS-1:0] i_fine_lo_y,
    input  logic signed [COORD_BITS-1:0] i_fine_lo_z,
    input  logic signed [COORD_BITS-1:0] i_fine_hi_x,
    input  logic signed [COORD_BITS-1:0] i_fine_hi_y,
    input  logic signed [COORD_BITS-1:0] i_fine_hi_z,
    input  logic signed [COORD_BITS-1:0] i_coarse_lo_x,
    input  logic signed [COORD_BITS-1:0] i_coarse_lo_y,
    input  logic signed [COORD_BITS-1:0] i_coarse_lo_z,
    input  logic signed [COORD_BITS-1:0] i_coarse_hi_x,
    input  logic signed [COORD_BITS-1:0] i_coarse_hi_y,
    input  logic signed [COORD_BITS-1:0] i_coarse_hi_z,

    output logic                         o_done,
    output logic signed [COORD_BITS-1:0] o_out_lo_x,
    output logic signed [COORD_BITS-1:0] o_out_lo_y,
    output logic signed [COORD_BITS-1:0] o_out_lo_z,
    output logic signed [COORD_BITS-1:0] o_out_hi_x,
    output logic signed [COORD_BITS-1:0] o_out_hi_y,
    output logic signed [COORD_BITS-1:0] o_out_hi_z,
    output logic                         o_no_contact
);

    localparam int W   = COORD_BITS;
    localparam int EW  = COORD_BITS + 4;
    localparam int NDS = (W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int LAT = NDS + 6;

    localparam logic signed [EW-1:0] SAT_HI = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic signed [EW-1:0] f_max(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [EW-1:0] f_min(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // Multiply by a stencil step in -2..1
    function automatic logic signed [EW-1:0] f_mstep(input logic signed [EW-1:0] v,
                                                     input logic [STEP_W-1:0]    s);
        logic signed [EW-1:0] res;
        case (s)
            STEP_POS:  res = v;
            STEP_NEG:  res = -v;
            STEP_NEG2: res = -(v <<< 1);
            default:   res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [W-1:0] f_sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[W-1:0];
    endfunction

    // Handshakes: the pipeline takes an item every cycle
    logic accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers
    logic [AXES_W-1:0]   r_active;
    logic [REFINE_W-1:0] r_refine [3];
    logic [STEP_W-1:0]   r_step   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_AXES_RST;
            for (int a = 0; a < 3; a++) begin
                r_refine[a] <= REFINE_RST;
                r_step[a]   <= STEP_RST;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_AXES: r_active    <= i_cfg_data[AXES_W-1:0];
                CFG_REFINE_X:    r_refine[0] <= i_cfg_data[REFINE_W-1:0];
                CFG_REFINE_Y:    r_refine[1] <= i_cfg_data[REFINE_W-1:0];
                CFG_REFINE_Z:    r_refine[2] <= i_cfg_data[REFINE_W-1:0];
                CFG_STEP_X:      r_step[0]   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:      r_step[1]   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Z:      r_step[2]   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Active axes: zero axes counts as one
    logic [2:0] axis_act;

    assign axis_act[0] = 1'b1;
    assign axis_act[1] = (r_active[1] == 1'b1);
    assign axis_act[2] = (r_active == 2'd3);

    // Valid bits travel alongside the data
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Input fields by axis
    logic signed [W-1:0] in_f_lo [3];
    logic signed [W-1:0] in_f_hi [3];
    logic signed [W-1:0] in_c_lo [3];
    logic signed [W-1:0] in_c_hi [3];

    assign in_f_lo[0] = i_fine_lo_x;
    assign in_f_lo[1] = i_fine_lo_y;
    assign in_f_lo[2] = i_fine_lo_z;
    assign in_f_hi[0] = i_fine_hi_x;
    assign in_f_hi[1] = i_fine_hi_y;
    assign in_f_hi[2] = i_fine_hi_z;
    assign in_c_lo[0] = i_coarse_lo_x;
    assign in_c_lo[1] = i_coarse_lo_y;
    assign in_c_lo[2] = i_coarse_lo_z;
    assign in_c_hi[0] = i_coarse_hi_x;
    assign in_c_hi[1] = i_coarse_hi_y;
    assign in_c_hi[2] = i_coarse_hi_z;

    // Stage D results per axis, consumed by the output stage
    logic signed [EW-1:0] r_d_ilo  [3];
    logic signed [EW-1:0] r_d_ihi  [3];
    logic signed [EW-1:0] r_d_alo  [3];
    logic signed [EW-1:0] r_d_ahi  [3];
    logic signed [EW-1:0] r_d_blo  [3];
    logic signed [EW-1:0] r_d_bhi  [3];
    logic [2:0]           r_d_emp;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W-1:0]  r_f_lo, r_f_hi, r_c_lo, r_c_hi;
        logic [REFINE_W-1:0]  eff_r;
        logic signed [W:0]    lo_num, hi_num, k_lo, k_hi;
        logic signed [W-1:0]  r_cl_d [NDS];
        logic signed [W-1:0]  r_ch_d [NDS];
        logic signed [EW-1:0] s_ext;

        // Input capture
        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_f_lo <= in_f_lo[a];
                r_f_hi <= in_f_hi[a];
                r_c_lo <= in_c_lo[a];
                r_c_hi <= in_c_hi[a];
            end
        end

        // Ceiling of the lower bound as floor((lo + r - 1) / r)
        assign eff_r  = (r_refine[a] == '0) ? REFINE_W'(1) : r_refine[a];
        assign lo_num = {r_f_lo[W-1], r_f_lo} + (W+1)'(eff_r) - (W+1)'(1);
        assign hi_num = {r_f_hi[W-1], r_f_hi};
        assign s_ext  = EW'($signed(r_step[a]));

        cfsb_fdiv #(.COORD_BITS(COORD_BITS)) u_div_lo (
            .i_clk    (i_clk),
            .i_num    (lo_num),
            .i_refine (eff_r),
            .o_quot   (k_lo)
        );

        cfsb_fdiv #(.COORD_BITS(COORD_BITS)) u_div_hi (
            .i_clk    (i_clk),
            .i_num    (hi_num),
            .i_refine (eff_r),
            .o_quot   (k_hi)
        );

        // Coarse bounds wait out the divider latency
        always_ff @(posedge i_clk) begin
            r_cl_d[0] <= r_c_lo;
            r_ch_d[0] <= r_c_hi;
            for (int i = 1; i < NDS; i++) begin
                r_cl_d[i] <= r_cl_d[i-1];
                r_ch_d[i] <= r_ch_d[i-1];
            end
        end

        // Stage A: grow by one layer and clip to the coarse box
        logic signed [EW-1:0] a_kl, a_kh, a_dk, n_a_ilo, n_a_ihi, n_a_sc;
        logic signed [EW-1:0] r_a_ilo, r_a_ihi, r_a_sc, r_a_kl, r_a_kh;

        always_comb begin
            a_kl    = EW'(k_lo);
            a_kh    = EW'(k_hi);
            a_dk    = a_kh - a_kl;
            n_a_ilo = f_max(a_kl - EW'(1), EW'(r_cl_d[NDS-1]));
            n_a_ihi = f_min(a_kh + EW'(1), EW'(r_ch_d[NDS-1]));
            n_a_sc  = (a_dk < -EW'(1)) ? -EW'(1) : a_dk;
        end

        always_ff @(posedge i_clk) begin
            r_a_ilo <= n_a_ilo;
            r_a_ihi <= n_a_ihi;
            r_a_sc  <= n_a_sc;
            r_a_kl  <= a_kl;
            r_a_kh  <= a_kh;
        end

        // Stage B: emptiness, clipped extent, coarsened shift
        logic signed [EW-1:0] b_di, n_b_si, n_b_scs;
        logic signed [EW-1:0] r_b_ilo, r_b_ihi, r_b_kl, r_b_kh, r_b_si, r_b_scs;
        logic                 r_b_emp;

        always_comb begin
            b_di    = r_a_ihi - r_a_ilo;
            n_b_si  = (b_di < -EW'(1)) ? -EW'(1) : b_di;
            n_b_scs = f_mstep(r_a_sc, r_step[a]);
        end

        always_ff @(posedge i_clk) begin
            r_b_ilo <= r_a_ilo;
            r_b_ihi <= r_a_ihi;
            r_b_kl  <= r_a_kl;
            r_b_kh  <= r_a_kh;
            r_b_si  <= n_b_si;
            r_b_scs <= n_b_scs;
            r_b_emp <= (r_a_ilo > r_a_ihi);
        end

        // Stage C: shift both boxes against the stencil direction
        logic signed [EW-1:0] c_sis;
        logic signed [EW-1:0] r_c_ilo, r_c_ihi, r_c_kl, r_c_kh;
        logic signed [EW-1:0] r_c_talo, r_c_tahi, r_c_tblo, r_c_tbhi;
        logic                 r_c_emp;

        assign c_sis = f_mstep(r_b_si, r_step[a]);

        always_ff @(posedge i_clk) begin
            r_c_ilo  <= r_b_ilo;
            r_c_ihi  <= r_b_ihi;
            r_c_kl   <= r_b_kl;
            r_c_kh   <= r_b_kh;
            r_c_talo <= r_b_ilo - c_sis;
            r_c_tahi <= r_b_ihi - c_sis;
            r_c_tblo <= r_b_kl - r_b_scs;
            r_c_tbhi <= r_b_kh - r_b_scs;
            r_c_emp  <= r_b_emp;
        end

        // Stage D: clip to self, step the coarsened box
        always_ff @(posedge i_clk) begin
            r_d_ilo[a] <= r_c_ilo;
            r_d_ihi[a] <= r_c_ihi;
            r_d_alo[a] <= f_max(r_c_talo, r_c_ilo);
            r_d_ahi[a] <= f_min(r_c_tahi, r_c_ihi);
            r_d_blo[a] <= f_max(r_c_tblo, r_c_kl) - s_ext;
            r_d_bhi[a] <= f_min(r_c_tbhi, r_c_kh) - s_ext;
            r_d_emp[a] <= r_c_emp;
        end
    end

    // Output stage: intersect, pick the empty box if any active axis missed
    logic                 emp_any;
    logic [W-1:0]         n_o_lo [3];
    logic [W-1:0]         n_o_hi [3];
    logic signed [EW-1:0] sel_lo [3];
    logic signed [EW-1:0] sel_hi [3];
    logic [W-1:0]         r_o_lo [3];
    logic [W-1:0]         r_o_hi [3];
    logic                 r_o_nc;

    assign emp_any = |(r_d_emp & axis_act);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sel_lo[a] = emp_any ? r_d_ilo[a] : f_max(r_d_blo[a], r_d_alo[a]);
            sel_hi[a] = emp_any ? r_d_ihi[a] : f_min(r_d_bhi[a], r_d_ahi[a]);
            n_o_lo[a] = axis_act[a] ? f_sat(sel_lo[a]) : '0;
            n_o_hi[a] = axis_act[a] ? f_sat(sel_hi[a]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_o_lo[a] <= n_o_lo[a];
            r_o_hi[a] <= n_o_hi[a];
        end
        r_o_nc <= emp_any;
    end

    assign o_done       = r_vld[LAT-1];
    assign o_out_lo_x   = r_o_lo[0];
    assign o_out_lo_y   = r_o_lo[1];
    assign o_out_lo_z   = r_o_lo[2];
    assign o_out_hi_x   = r_o_hi[0];
    assign o_out_hi_y   = r_o_hi[1];
    assign o_out_hi_z   = r_o_hi[2];
    assign o_no_contact = r_o_nc;

endmodule

/* rtl/cfsb_fdiv.sv */
// Pipelined signed floor division by a small unsigned factor (1..31).
// Depends on cfsb_pkg; the quotient is taken from the last stage register.
module cfsb_fdiv
    import cfsb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic signed [COORD_BITS:0] i_num,
    input  logic [REFINE_W-1:0]        i_refine,
    output logic signed [COORD_BITS:0] o_quot
);

    localparam int MW  = COORD_BITS;
    localparam int NDS = (MW + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int PW  = NDS * DIV_DIGITS;

    // Fold negative numerators: floor(x/r) = ~floor(~x/r) for x < 0
    logic          num_neg;
    logic [MW-1:0] num_mag;
    logic [PW-1:0] num_pad;

    assign num_neg = i_num[MW];
    assign num_mag = num_neg ? ~i_num[MW-1:0] : i_num[MW-1:0];
    assign num_pad = PW'(num_mag);

    // Stage registers: numerator bits shift out, quotient bits shift in
    logic [PW-1:0]       r_q   [NDS];
    logic                r_neg [NDS];
    logic [REFINE_W-1:0] r_rem [NDS-1];

    for (genvar g = 0; g < NDS; g++) begin : g_stage
        logic [PW-1:0]       q_in;
        logic [REFINE_W-1:0] rem_in;
        logic                neg_in;
        logic [PW-1:0]       n_q;
        logic [REFINE_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign q_in   = num_pad;
            assign rem_in = '0;
            assign neg_in = num_neg;
        end else begin : g_next
            assign q_in   = r_q[g-1];
            assign rem_in = r_rem[g-1];
            assign neg_in = r_neg[g-1];
        end

        // Restoring long division, DIV_DIGITS quotient bits per stage
        always_comb begin
            logic [REFINE_W:0] t;
            n_q   = q_in;
            n_rem = rem_in;
            for (int i = 0; i < DIV_DIGITS; i++) begin
                t   = {n_rem, n_q[PW-1]};
                n_q = {n_q[PW-2:0], 1'b0};
                if (t >= {1'b0, i_refine}) begin
                    t      = t - {1'b0, i_refine};
                    n_q[0] = 1'b1;
                end
                n_rem = t[REFINE_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[g]   <= n_q;
            r_neg[g] <= neg_in;
        end

        if (g < NDS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
            end
        end
    end

    // Unfold the sign of the quotient
    assign o_quot = r_neg[NDS-1] ? ~{1'b0, r_q[NDS-1][MW-1:0]}
                                 :  {1'b0, r_q[NDS-1][MW-1:0]};

endmodule

/* tb/sv/coarse_fine_stencil_box_top_tb.sv */
// Self-checking testbench for coarse_fine_stencil_box_top: drives box pairs and register
// writes, predicts each coupling box in SystemVerilog and checks every result strobe.
// Depends on cfsb_pkg and the coarse_fine_stencil_box_top RTL.
module coarse_fine_stencil_box_top_tb;
    import cfsb_pkg::*;

    localparam int     CW             = COORD_BITS_DEF;
    localparam int     LATENCY        = (CW + 3) / 4 + 6;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PRINT_LIMIT    = 100;
    localparam longint COORD_MAX      = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN      = -COORD_MAX - 1;

    // One input item: fine and coarse box corners, index 0..2 = x..z
    typedef struct packed {
        logic [2:0][CW-1:0] fine_lo;
        logic [2:0][CW-1:0] fine_hi;
        logic [2:0][CW-1:0] coarse_lo;
        logic [2:0][CW-1:0] coarse_hi;
    } t_box_pair;

    // One result item
    typedef struct packed {
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic               no_contact;
    } t_coupling;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ACTIVE_AXES;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    t_box_pair             drv = '0;
    logic                  o_done;
    logic signed [CW-1:0]  o_out_lo_x, o_out_lo_y, o_out_lo_z;
    logic signed [CW-1:0]  o_out_hi_x, o_out_hi_y, o_out_hi_z;
    logic                  o_no_contact;

    // Register shadow, starts at the reset values
    logic [AXES_W-1:0]        cfg_axes = ACTIVE_AXES_RST;
    logic [2:0][REFINE_W-1:0] cfg_refine = {3{REFINE_RST}};
    logic [2:0][STEP_W-1:0]   cfg_step = {3{STEP_RST}};

    t_coupling expected_boxes[$];
    int        gap_pct = 0;
    int        errors = 0;
    int        items_sent = 0;
    int        results_checked = 0;
    int        misses_seen = 0;
    int        settings_used = 1;
    int        idle_cycles = 0;

    coarse_fine_stencil_box_top #(.COORD_BITS(CW)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_fine_lo_x   (drv.fine_lo[0]),
        .i_fine_lo_y   (drv.fine_lo[1]),
        .i_fine_lo_z   (drv.fine_lo[2]),
        .i_fine_hi_x   (drv.fine_hi[0]),
        .i_fine_hi_y   (drv.fine_hi[1]),
        .i_fine_hi_z   (drv.fine_hi[2]),
        .i_coarse_lo_x (drv.coarse_lo[0]),
        .i_coarse_lo_y (drv.coarse_lo[1]),
        .i_coarse_lo_z (drv.coarse_lo[2]),
        .i_coarse_hi_x (drv.coarse_hi[0]),
        .i_coarse_hi_y (drv.coarse_hi[1]),
        .i_coarse_hi_z (drv.coarse_hi[2]),
        .o_done        (o_done),
        .o_out_lo_x    (o_out_lo_x),
        .o_out_lo_y    (o_out_lo_y),
        .o_out_lo_z    (o_out_lo_z),
        .o_out_hi_x    (o_out_hi_x),
        .o_out_hi_y    (o_out_hi_y),
        .o_out_hi_z    (o_out_hi_z),
        .o_no_contact  (o_no_contact)
    );

    // Clock, period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Arithmetic helpers
    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    // Non-negative remainder and floor quotient, also for negative values
    function automatic longint floor_mod(input longint v, input longint r);
        longint m;
        m = v % r;
        return (m < 0) ? m + r : m;
    endfunction

    function automatic longint floor_div(input longint v, input longint r);
        return (v - floor_mod(v, r)) / r;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[CW-1:0];
    endfunction

    function automatic longint refine_of(input int a);
        return (cfg_refine[a] == 0) ? 1 : longint'(cfg_refine[a]);
    endfunction

    // Expected coupling box for one box pair under the current registers
    function automatic t_coupling predict_coupling(input t_box_pair b);
        t_coupling res;
        longint    grow_lo[3], grow_hi[3], cpl_lo[3], cpl_hi[3];
        longint    f_lo, f_hi, c_lo, c_hi, r, s, m, k_lo, k_hi, sc, si;
        longint    a_lo, a_hi, b_lo, b_hi;
        int        naxes, a;
        bit        miss;
        naxes = int'(cfg_axes);
        if (naxes < 1) naxes = 1;
        miss = 1'b0;
        for (a = 0; a < 3; a++) begin
            grow_lo[a] = 0;
            grow_hi[a] = 0;
            cpl_lo[a]  = 0;
            cpl_hi[a]  = 0;
            if (a < naxes) begin
                f_lo = $signed(b.fine_lo[a]);
                f_hi = $signed(b.fine_hi[a]);
                c_lo = $signed(b.coarse_lo[a]);
                c_hi = $signed(b.coarse_hi[a]);
                r    = refine_of(a);
                s    = $signed(cfg_step[a]);
                // round fine lower bound up, then coarsen
                m = floor_mod(f_lo, r);
                if (m != 0) f_lo = f_lo + r - m;
                k_lo = floor_div(f_lo, r);
                k_hi = floor_div(f_hi, r);
                sc   = lmax(k_hi - k_lo + 1, 0) - 1;
                // grow by one and clip to the coarse box
                grow_lo[a] = lmax(k_lo - 1, c_lo);
                grow_hi[a] = lmin(k_hi + 1, c_hi);
                if (grow_lo[a] > grow_hi[a]) miss = 1'b1;
                si = lmax(grow_hi[a] - grow_lo[a] + 1, 0) - 1;
                // shift against the stencil direction and intersect
                a_lo = lmax(grow_lo[a] - si * s, grow_lo[a]);
                a_hi = lmin(grow_hi[a] - si * s, grow_hi[a]);
                b_lo = lmax(k_lo - sc * s, k_lo) - s;
                b_hi = lmin(k_hi - sc * s, k_hi) - s;
                cpl_lo[a] = lmax(b_lo, a_lo);
                cpl_hi[a] = lmin(b_hi, a_hi);
            end
        end
        for (a = 0; a < 3; a++) begin
            res.lo[a] = clamp_coord(miss ? grow_lo[a] : cpl_lo[a]);
            res.hi[a] = clamp_coord(miss ? grow_hi[a] : cpl_hi[a]);
        end
        res.no_contact = miss;
        return res;
    endfunction

    // Same corners on every axis
    function automatic t_box_pair uniform_box(input longint flo, input longint fhi,
                                              input longint clo, input longint chi);
        t_box_pair b;
        int        a;
        for (a = 0; a < 3; a++) begin
            b.fine_lo[a]   = clamp_coord(flo);
            b.fine_hi[a]   = clamp_coord(fhi);
            b.coarse_lo[a] = clamp_coord(clo);
            b.coarse_hi[a] = clamp_coord(chi);
        end
        return b;
    endfunction

    function automatic logic [CW-1:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return clamp_coord(COORD_MIN);
            1:       return clamp_coord(COORD_MAX);
            2:       return '0;
            3:       return '1;
            4:       return CW'(1);
            default: return CW'($urandom());
        endcase
    endfunction

    // Mostly coupled boxes around the coarsened fine box, the rest raw or corner values
    function automatic t_box_pair random_box_pair();
        t_box_pair b;
        int        kind, a;
        longint    r, flo, fhi, clo, chi, off;
        kind = $urandom_range(0, 99);
        for (a = 0; a < 3; a++) begin
            if (kind < 70) begin
                r = refine_of(a);
                case ($urandom_range(0, 9))
                    0:       flo = COORD_MAX - longint'($urandom_range(0, 64));
                    1:       flo = COORD_MIN + longint'($urandom_range(0, 64));
                    default: flo = longint'($urandom_range(0, 4000)) - 2000;
                endcase
                fhi = flo + longint'($urandom_range(0, 6 * int'(r)));
                if ($urandom_range(0, 9) == 0) fhi = flo - longint'($urandom_range(1, 8));
                clo = floor_div(flo, r) + longint'($urandom_range(0, 6)) - 3;
                chi = floor_div(fhi, r) + longint'($urandom_range(0, 6)) - 3;
                if ($urandom_range(0, 6) == 0) begin
                    off = longint'($urandom_range(2, 40));
                    if ($urandom_range(0, 1) == 1) off = -off;
                    clo = clo + off;
                    chi = chi + off;
                end
                b.fine_lo[a]   = clamp_coord(flo);
                b.fine_hi[a]   = clamp_coord(fhi);
                b.coarse_lo[a] = clamp_coord(clo);
                b.coarse_hi[a] = clamp_coord(chi);
            end else if (kind < 85) begin
                b.fine_lo[a]   = CW'($urandom());
                b.fine_hi[a]   = CW'($urandom());
                b.coarse_lo[a] = CW'($urandom());
                b.coarse_hi[a] = CW'($urandom());
            end else begin
                b.fine_lo[a]   = corner_value();
                b.fine_hi[a]   = corner_value();
                b.coarse_lo[a] = corner_value();
                b.coarse_hi[a] = corner_value();
            end
        end
        return b;
    endfunction

    // Mismatch report: one line each, printing capped, all counted
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_LIMIT)
            $display("MISMATCH at %0t, result %0d, %s: got %0d expected %0d",
                     $time, results_checked, what, got, want);
        errors++;
    endtask

    // Send one box pair, with random gaps before it
    task automatic send_box(input t_box_pair b);
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        drv   = b;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Register write; the shadow follows at the handshake
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        start       = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ACTIVE_AXES: cfg_axes      = data[AXES_W-1:0];
            CFG_REFINE_X:    cfg_refine[0] = data[REFINE_W-1:0];
            CFG_REFINE_Y:    cfg_refine[1] = data[REFINE_W-1:0];
            CFG_REFINE_Z:    cfg_refine[2] = data[REFINE_W-1:0];
            CFG_STEP_X:      cfg_step[0]   = data[STEP_W-1:0];
            CFG_STEP_Y:      cfg_step[1]   = data[STEP_W-1:0];
            CFG_STEP_Z:      cfg_step[2]   = data[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] axes,
                             input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] ry,
                             input logic [CFG_DATA_W-1:0] rz, input logic [CFG_DATA_W-1:0] sx,
                             input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] sz);
        cfg_write(CFG_ACTIVE_AXES, axes);
        cfg_write(CFG_REFINE_X, rx);
        cfg_write(CFG_REFINE_Y, ry);
        cfg_write(CFG_REFINE_Z, rz);
        cfg_write(CFG_STEP_X, sx);
        cfg_write(CFG_STEP_Y, sy);
        cfg_write(CFG_STEP_Z, sz);
        settings_used++;
    endtask

    // Let every expected result arrive, then the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Record accepted items, check each result strobe
    always @(posedge i_clk) begin
        t_coupling got, want;
        int        a;
        if (i_rst_n && start && !busy) begin
            expected_boxes.push_back(predict_coupling(drv));
            items_sent++;
        end
        if (i_rst_n && o_done) begin
            got.lo         = {o_out_lo_z, o_out_lo_y, o_out_lo_x};
            got.hi         = {o_out_hi_z, o_out_hi_y, o_out_hi_x};
            got.no_contact = o_no_contact;
            if (expected_boxes.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = expected_boxes.pop_front();
                for (a = 0; a < 3; a++) begin
                    if (got.lo[a] !== want.lo[a])
                        report_mismatch($sformatf("lo axis %0d", a),
                                        longint'($signed(got.lo[a])),
                                        longint'($signed(want.lo[a])));
                    if (got.hi[a] !== want.hi[a])
                        report_mismatch($sformatf("hi axis %0d", a),
                                        longint'($signed(got.hi[a])),
                                        longint'($signed(want.hi[a])));
                end
                if (got.no_contact !== want.no_contact)
                    report_mismatch("no_contact", longint'(got.no_contact),
                                    longint'(want.no_contact));
                if (want.no_contact) misses_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any handshake or result ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d results pending",
                     idle_cycles, expected_boxes.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset register values, extreme and degenerate boxes
    task automatic test_reset_defaults();
        t_box_pair b;
        send_box(uniform_box(0, 0, 0, 0));
        send_box(uniform_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        // inverted fine box
        send_box(uniform_box(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        // grown box misses the coarse box
        send_box(uniform_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        // negative coordinates, inverted coarse box on z
        b = uniform_box(-7, -3, -10, 10);
        b.fine_lo[1]   = clamp_coord(-8);
        b.fine_hi[1]   = clamp_coord(-1);
        b.coarse_lo[2] = clamp_coord(5);
        b.coarse_hi[2] = clamp_coord(-5);
        send_box(b);
        wait_idle();
    endtask

    // Zero axes, zero and oversized factors, step of -2, saturation, single-axis miss
    task automatic test_special_cases();
        t_box_pair b;
        // zero axes acts as x only; zero factor acts as one
        write_all(0, 0, 16, 2, CFG_DATA_W'(STEP_NEG2), CFG_DATA_W'(STEP_POS),
                  CFG_DATA_W'(STEP_ZERO));
        b = uniform_box(0, 0, COORD_MAX, COORD_MIN);
        b.fine_lo[0]   = clamp_coord(COORD_MAX - 7);
        b.fine_hi[0]   = clamp_coord(COORD_MAX);
        b.coarse_lo[0] = clamp_coord(COORD_MAX - 17);
        b.coarse_hi[0] = clamp_coord(COORD_MAX);
        send_box(b);
        b.fine_lo[0]   = clamp_coord(COORD_MIN);
        b.fine_hi[0]   = clamp_coord(COORD_MIN + 9);
        b.coarse_lo[0] = clamp_coord(COORD_MIN);
        b.coarse_hi[0] = clamp_coord(COORD_MIN + 20);
        send_box(b);
        send_box(uniform_box(-5, 5, -3, 3));
        wait_idle();
        // factors above sixteen, two axes
        write_all(2, 31, 17, 16, CFG_DATA_W'(STEP_NEG), CFG_DATA_W'(STEP_NEG2),
                  CFG_DATA_W'(STEP_POS));
        send_box(uniform_box(-100, 100, -10, 10));
        send_box(uniform_box(COORD_MAX - 40, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(uniform_box(-31, -1, -1, -1));
        wait_idle();
        // mixed factors, all three axes
        write_all(3, 1, 16, 5, CFG_DATA_W'(STEP_POS), CFG_DATA_W'(STEP_ZERO),
                  CFG_DATA_W'(STEP_NEG));
        send_box(uniform_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(uniform_box(0, 15, 0, 0));
        send_box(uniform_box(16, 16, 1, 1));
        send_box(uniform_box(-1, -1, -1, -1));
        // contact on x and y, miss on z alone
        b = uniform_box(0, 100, 0, 100);
        b.coarse_lo[2] = clamp_coord(50);
        b.coarse_hi[2] = clamp_coord(60);
        send_box(b);
        wait_idle();
    endtask

    // Random register settings, each followed by a block of random box pairs
    task automatic test_random_traffic(input int idle_pct, input int blocks,
                                       input int per_block);
        int j, n;
        logic [CFG_DATA_W-1:0] rf[3];
        gap_pct = idle_pct;
        for (j = 0; j < blocks; j++) begin
            if (j == 0) begin
                write_all(3, 16, 16, 16, CFG_DATA_W'(STEP_NEG), CFG_DATA_W'(STEP_NEG),
                          CFG_DATA_W'(STEP_NEG));
            end else if (j == 1) begin
                write_all(3, 1, 1, 1, CFG_DATA_W'(STEP_POS), CFG_DATA_W'(STEP_POS),
                          CFG_DATA_W'(STEP_POS));
            end else begin
                for (n = 0; n < 3; n++)
                    rf[n] = ($urandom_range(0, 9) < 8) ? CFG_DATA_W'($urandom_range(1, 16))
                                                        : CFG_DATA_W'($urandom_range(0, 31));
                write_all(CFG_DATA_W'($urandom_range(0, 31)), rf[0], rf[1], rf[2],
                          CFG_DATA_W'($urandom_range(0, 31)),
                          CFG_DATA_W'($urandom_range(0, 31)),
                          CFG_DATA_W'($urandom_range(0, 31)));
            end
            for (n = 0; n < per_block; n++)
                send_box(random_box_pair());
            wait_idle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_random_traffic(14, 9, 50);
        test_random_traffic(65, 9, 50);
        test_random_traffic(0, 9, 50);

        $display("Sent %0d box pairs under %0d register settings with idle and back-to-back input.",
                 items_sent, settings_used);
        $display("Checked %0d coupling boxes, %0d of them with no contact; %0d mismatches.",
                 results_checked, misses_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
